// ===== rtl/k_clique_counter_defines.svh =====
// ----------------------------------------------------------------------------
// k_clique_counter_defines
// assertion macros for the clique counter
// ----------------------------------------------------------------------------
`ifndef K_CLIQUE_COUNTER_DEFINES_SVH
`define K_CLIQUE_COUNTER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define KCC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define KCC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define KCC_ASSERT_SAME(lbl, ante, cons, msg)
`define KCC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/kcc_pkg.sv =====
// ----------------------------------------------------------------------------
// kcc_pkg
// shared types and constants of the clique counter
// ----------------------------------------------------------------------------
package kcc_pkg;

	localparam int MAX_VERTICES_DEF = 64;
	localparam int MAX_CLIQUE_DEF   = 16;

	localparam int CFG_DW = 7;
	localparam int CFG_IW = 2;

	localparam logic [CFG_IW-1:0] CFG_VERTEX_COUNT = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_CLIQUE_SIZE  = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_START_OFFSET = 2'd2;
	localparam logic [CFG_IW-1:0] CFG_START_STRIDE = 2'd3;

	localparam logic [1:0] MODE_CLEAR = 2'd0;
	localparam logic [1:0] MODE_EDGE  = 2'd1;
	localparam logic [1:0] MODE_COUNT = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [5:0] first_vertex;
		logic [5:0] second_vertex;
	} in_word_t;

	typedef struct packed {
		logic [31:0] clique_count;
		logic        saturated;
	} out_word_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EDGE_RA,
		S_EDGE_WA,
		S_EDGE_WB,
		S_CINIT,
		S_START,
		S_ROOT,
		S_STEP,
		S_EXPAND,
		S_ADD,
		S_NEXT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load_in;
		logic clear_rows;
		logic edge_rd_a;
		logic edge_wr_a;
		logic edge_wr_b;
		logic count_init;
		logic start_read;
		logic root_load;
		logic step_push;
		logic expand;
		logic chunk_clr;
		logic add_chunk;
		logic add_one;
		logic level_pop;
		logic next_start;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic edge_ok;
		logic k_valid;
		logic k_is_one;
		logic start_ok;
		logic at_max;
		logic leaf;
		logic cur_empty;
		logic depth_zero;
		logic chunk_last;
		logic last_start;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/kcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// kcc_ctrl
// sequencer for edge loading and the depth-first clique search
// ----------------------------------------------------------------------------
module kcc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [1:0]    in_mode,
	output logic          in_stall,
	input  kcc_pkg::sts_t sts,
	output kcc_pkg::cmd_t cmd
);

	kcc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kcc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != kcc_pkg::S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			kcc_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					case (in_mode)
						kcc_pkg::MODE_CLEAR: cmd.clear_rows = 1'b1;
						kcc_pkg::MODE_EDGE:  state_d = kcc_pkg::S_EDGE_RA;
						kcc_pkg::MODE_COUNT: state_d = kcc_pkg::S_CINIT;
						default: ;
					endcase
				end
			end
			kcc_pkg::S_EDGE_RA: begin
				if (sts.edge_ok) begin
					cmd.edge_rd_a = 1'b1;
					state_d = kcc_pkg::S_EDGE_WA;
				end else begin
					state_d = kcc_pkg::S_IDLE;
				end
			end
			kcc_pkg::S_EDGE_WA: begin
				cmd.edge_wr_a = 1'b1;
				state_d = kcc_pkg::S_EDGE_WB;
			end
			kcc_pkg::S_EDGE_WB: begin
				cmd.edge_wr_b = 1'b1;
				state_d = kcc_pkg::S_IDLE;
			end
			kcc_pkg::S_CINIT: begin
				cmd.count_init = 1'b1;
				state_d = sts.k_valid ? kcc_pkg::S_START : kcc_pkg::S_DONE;
			end
			kcc_pkg::S_START: begin
				if (!sts.start_ok) begin
					state_d = kcc_pkg::S_DONE;
				end else if (sts.k_is_one) begin
					cmd.add_one = 1'b1;
					state_d = kcc_pkg::S_NEXT;
				end else begin
					cmd.start_read = 1'b1;
					state_d = kcc_pkg::S_ROOT;
				end
			end
			kcc_pkg::S_ROOT: begin
				cmd.root_load = 1'b1;
				state_d = kcc_pkg::S_STEP;
			end
			kcc_pkg::S_STEP: begin
				if (sts.at_max) begin
					state_d = kcc_pkg::S_DONE;
				end else if (sts.leaf) begin
					cmd.chunk_clr = 1'b1;
					state_d = kcc_pkg::S_ADD;
				end else if (sts.cur_empty) begin
					if (sts.depth_zero) begin
						state_d = kcc_pkg::S_NEXT;
					end else begin
						cmd.level_pop = 1'b1;
					end
				end else begin
					cmd.step_push = 1'b1;
					state_d = kcc_pkg::S_EXPAND;
				end
			end
			kcc_pkg::S_EXPAND: begin
				cmd.expand = 1'b1;
				state_d = kcc_pkg::S_STEP;
			end
			kcc_pkg::S_ADD: begin
				cmd.add_chunk = 1'b1;
				if (sts.chunk_last) begin
					if (sts.depth_zero) begin
						state_d = kcc_pkg::S_NEXT;
					end else begin
						cmd.level_pop = 1'b1;
						state_d = kcc_pkg::S_STEP;
					end
				end
			end
			kcc_pkg::S_NEXT: begin
				if (sts.last_start) begin
					state_d = kcc_pkg::S_DONE;
				end else begin
					cmd.next_start = 1'b1;
					state_d = kcc_pkg::S_START;
				end
			end
			kcc_pkg::S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = kcc_pkg::S_IDLE;
				end
			end
			default: state_d = kcc_pkg::S_IDLE;
		endcase
	end

endmodule

// ===== rtl/kcc_datapath.sv =====
// ----------------------------------------------------------------------------
// kcc_datapath
// adjacency memory, search stack, counter, config and output register
// ----------------------------------------------------------------------------
module kcc_datapath #(
	parameter int MAX_VERTICES = kcc_pkg::MAX_VERTICES_DEF,
	parameter int MAX_CLIQUE   = kcc_pkg::MAX_CLIQUE_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  kcc_pkg::in_word_t          in_word,
	input  logic                       cfg_we,
	input  logic [kcc_pkg::CFG_IW-1:0] cfg_index,
	input  logic [kcc_pkg::CFG_DW-1:0] cfg_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output kcc_pkg::out_word_t         out_word,
	input  kcc_pkg::cmd_t              cmd,
	output kcc_pkg::sts_t              sts
);

	localparam int VW   = $clog2(MAX_VERTICES);
	localparam int CW   = $clog2(MAX_VERTICES + 1);
	localparam int SVW  = ((CW > 7) ? CW : 7) + 1;
	localparam int DW   = (MAX_CLIQUE > 2) ? $clog2(MAX_CLIQUE) : 1;
	localparam int KW   = ((DW > 5) ? DW : 5) + 1;
	localparam int NCH  = (MAX_VERTICES + 7) / 8;
	localparam int CHW  = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int PADW = NCH * 8;

	// config
	logic [6:0] vc_q;
	logic [4:0] k_q;
	logic [5:0] off_q;
	logic [6:0] stride_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q     <= 7'd64;
			k_q      <= 5'd3;
			off_q    <= 6'd0;
			stride_q <= 7'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				kcc_pkg::CFG_VERTEX_COUNT: vc_q     <= cfg_data[6:0];
				kcc_pkg::CFG_CLIQUE_SIZE:  k_q      <= cfg_data[4:0];
				kcc_pkg::CFG_START_OFFSET: off_q    <= cfg_data[5:0];
				kcc_pkg::CFG_START_STRIDE: stride_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	logic [SVW-1:0] nv;
	always_comb begin
		nv = (SVW'(vc_q) > SVW'(MAX_VERTICES)) ? SVW'(MAX_VERTICES) : SVW'(vc_q);
	end

	// latched item
	logic [5:0] a_q, b_q;
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			a_q <= in_word.first_vertex;
			b_q <= in_word.second_vertex;
		end
	end

	logic [VW-1:0] a_idx, b_idx;
	assign a_idx = VW'(a_q);
	assign b_idx = VW'(b_q);

	// search registers
	logic [SVW-1:0]          sv_q;
	logic [MAX_VERTICES-1:0] cur_q;
	logic [DW-1:0]           depth_q;
	logic [CHW-1:0]          chunk_q;
	logic [31:0]             count_q;
	logic [MAX_VERTICES-1:0] stack_q [MAX_CLIQUE];

	// lowest candidate
	logic [VW-1:0] low_idx;
	always_comb begin
		low_idx = '0;
		for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
			if (cur_q[i]) low_idx = VW'(i);
		end
	end

	// adjacency memory with per-row valid bits
	logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] row_valid_q;
	logic [MAX_VERTICES-1:0] rd_data_q;
	logic                    rd_valid_q;
	logic [MAX_VERTICES-1:0] row_data;
	logic                    rd_en, wr_en;
	logic [VW-1:0]           rd_addr, wr_addr;
	logic [MAX_VERTICES-1:0] wr_data;

	assign row_data = rd_valid_q ? rd_data_q : '0;

	always_comb begin
		rd_en   = cmd.edge_rd_a | cmd.edge_wr_a | cmd.start_read | cmd.step_push;
		rd_addr = low_idx;
		if (cmd.edge_rd_a) rd_addr = a_idx;
		else if (cmd.edge_wr_a) rd_addr = b_idx;
		else if (cmd.start_read) rd_addr = sv_q[VW-1:0];
		wr_en   = cmd.edge_wr_a | cmd.edge_wr_b;
		wr_addr = cmd.edge_wr_a ? a_idx : b_idx;
		wr_data = row_data | (cmd.edge_wr_a ? (MAX_VERTICES'(1) << b_idx)
			: (MAX_VERTICES'(1) << a_idx));
	end

	always_ff @(posedge clk) begin
		if (wr_en) adj_mem[wr_addr] <= wr_data;
		if (rd_en) rd_data_q <= adj_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			if (cmd.clear_rows) row_valid_q <= '0;
			else if (wr_en) row_valid_q[wr_addr] <= 1'b1;
			if (rd_en) rd_valid_q <= row_valid_q[rd_addr];
		end
	end

	// root candidate mask: above start, below vertex count
	logic [MAX_VERTICES-1:0] root_mask;
	always_comb begin
		for (int i = 0; i < MAX_VERTICES; i++) begin
			root_mask[i] = (SVW'(i) > sv_q) && (SVW'(i) < nv);
		end
	end

	// popcount of one chunk
	logic [PADW-1:0] cur_pad;
	logic [7:0]      chunk;
	logic [3:0]      chunk_pop;
	assign cur_pad = PADW'(cur_q);
	assign chunk   = cur_pad[chunk_q*8 +: 8];
	always_comb begin
		chunk_pop = '0;
		for (int i = 0; i < 8; i++) begin
			chunk_pop = chunk_pop + 4'(chunk[i]);
		end
	end

	logic [3:0]  addend;
	logic [32:0] sum;
	assign addend = cmd.add_one ? 4'd1 : chunk_pop;
	assign sum    = {1'b0, count_q} + 33'(addend);

	logic at_max;
	assign at_max = (count_q == 32'hFFFF_FFFF);

	always_ff @(posedge clk) begin
		if (cmd.count_init) begin
			sv_q    <= SVW'(off_q);
			depth_q <= '0;
		end else if (cmd.next_start) begin
			sv_q <= sv_q + SVW'(stride_q);
		end
		if (cmd.root_load) begin
			cur_q   <= row_data & root_mask;
			depth_q <= '0;
		end else if (cmd.step_push) begin
			cur_q            <= cur_q & ~(MAX_VERTICES'(1) << low_idx);
			stack_q[depth_q] <= cur_q & ~(MAX_VERTICES'(1) << low_idx);
		end else if (cmd.expand) begin
			cur_q   <= cur_q & row_data;
			depth_q <= depth_q + 1'b1;
		end else if (cmd.level_pop) begin
			cur_q   <= stack_q[depth_q - 1'b1];
			depth_q <= depth_q - 1'b1;
		end
		if (cmd.chunk_clr) chunk_q <= '0;
		else if (cmd.add_chunk) chunk_q <= chunk_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.count_init) begin
			count_q <= '0;
		end else if (cmd.add_chunk || cmd.add_one) begin
			count_q <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
		end
	end

	// output register
	logic               out_valid_q;
	kcc_pkg::out_word_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.clique_count <= count_q;
			out_q.saturated    <= at_max;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	always_comb begin
		sts.edge_ok    = (SVW'(a_q) < nv) && (SVW'(b_q) < nv);
		sts.k_valid    = (k_q != 5'd0) && (KW'(k_q) <= KW'(MAX_CLIQUE));
		sts.k_is_one   = (k_q == 5'd1);
		sts.start_ok   = (sv_q < nv);
		sts.at_max     = at_max;
		sts.leaf       = (KW'(depth_q) + KW'(2)) == KW'(k_q);
		sts.cur_empty  = (cur_q == '0);
		sts.depth_zero = (depth_q == '0);
		sts.chunk_last = (chunk_q == CHW'(NCH - 1));
		sts.last_start = (stride_q == 7'd0) || at_max;
		sts.out_free   = !out_valid_q || !out_stall;
	end

endmodule

// ===== rtl/k_clique_counter.sv =====
// ----------------------------------------------------------------------------
// k_clique_counter
// clear is taken in idle; an edge passes through the read, write-a and write-b
// states (back to idle when out of range); a count inits and then searches
// search: a branch node reads its adjacency row and then expands; a leaf level
// is summed one 8-bit chunk at a time by popcount; one adjacency read port
// reset empties the graph at once through per-row valid bits
// ----------------------------------------------------------------------------
module k_clique_counter #(
	parameter int MAX_VERTICES = kcc_pkg::MAX_VERTICES_DEF,
	parameter int MAX_CLIQUE   = kcc_pkg::MAX_CLIQUE_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  kcc_pkg::in_word_t          in_word,
	output logic                       out_valid,
	input  logic                       out_stall,
	output kcc_pkg::out_word_t         out_word,
	input  logic                       cfg_we,
	input  logic [kcc_pkg::CFG_IW-1:0] cfg_index,
	input  logic [kcc_pkg::CFG_DW-1:0] cfg_data
);

	kcc_pkg::cmd_t cmd;
	kcc_pkg::sts_t sts;
	logic          count_acc;

	assign count_acc = in_valid && !in_stall && (in_word.mode == kcc_pkg::MODE_COUNT);

	kcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_mode  (in_word.mode),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	kcc_datapath #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_CLIQUE   (MAX_CLIQUE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_word   (in_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cmd       (cmd),
		.sts       (sts)
	);

`include "k_clique_counter_defines.svh"

	`KCC_ASSERT_NEXT(a_out_load, cmd.out_load, out_valid, "result word not presented")
	`KCC_ASSERT_NEXT(a_count_busy, count_acc, in_stall, "count word did not start a search")
	`KCC_ASSERT_SAME(a_sat_flag, out_valid && out_word.saturated, out_word.clique_count == 32'hFFFF_FFFF, "saturated flag without full count")

endmodule

// ===== tb/sv/k_clique_counter_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// k_clique_counter_checker
// Watches the input, output and register ports of the clique counter. It
// keeps its own copy of the adjacency matrix and the registers, works out
// the clique count for every accepted count word, and compares each result
// word with the oldest pending count.
// ----------------------------------------------------------------------------
module k_clique_counter_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  kcc_pkg::in_word_t          in_word,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  kcc_pkg::out_word_t         out_word,
	input  logic                       cfg_we,
	input  logic [kcc_pkg::CFG_IW-1:0] cfg_index,
	input  logic [kcc_pkg::CFG_DW-1:0] cfg_data,
	output int                         errors,
	output int                         pending,
	output int                         checked
);

	logic [63:0]        graph_rows [64];
	logic [6:0]         vcount;
	logic [4:0]         csize;
	logic [5:0]         soff;
	logic [6:0]         sstride;
	kcc_pkg::out_word_t count_q [$];

	function automatic logic [31:0] count_cliques();
		longint      total;
		logic [63:0] cand [16];
		logic [63:0] span;
		int          depth, v, u, nv;
		nv = (vcount > 64) ? 64 : vcount;
		total = 0;
		if (csize == 0 || csize > 16)
			return 32'd0;
		for (v = soff; v < nv; v += sstride) begin
			if (csize == 1) begin
				total++;
			end else begin
				span = '0;
				for (u = v + 1; u < nv; u++)
					span[u] = 1'b1;
				cand[0] = graph_rows[v] & span;
				depth = 0;
				forever begin
					if (depth + 2 == csize) begin
						total += $countones(cand[depth]);
						if (depth == 0)
							break;
						depth--;
					end else if (cand[depth] == '0) begin
						if (depth == 0)
							break;
						depth--;
					end else begin
						for (u = 0; u < 64; u++)
							if (cand[depth][u])
								break;
						cand[depth][u] = 1'b0;
						cand[depth + 1] = cand[depth] & graph_rows[u];
						depth++;
					end
				end
			end
			if (total >= 64'hFFFF_FFFF) begin
				total = 64'hFFFF_FFFF;
				break;
			end
			if (sstride == 0)
				break;
		end
		return total[31:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		kcc_pkg::out_word_t want;
		int                 nv;
		if (!arst_n) begin
			for (int r = 0; r < 64; r++)
				graph_rows[r] <= '0;
			vcount <= 7'd64;
			csize <= 5'd3;
			soff <= 6'd0;
			sstride <= 7'd1;
			count_q.delete();
			errors <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					kcc_pkg::CFG_VERTEX_COUNT: vcount <= cfg_data[6:0];
					kcc_pkg::CFG_CLIQUE_SIZE:  csize <= cfg_data[4:0];
					kcc_pkg::CFG_START_OFFSET: soff <= cfg_data[5:0];
					kcc_pkg::CFG_START_STRIDE: sstride <= cfg_data[6:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				nv = (vcount > 64) ? 64 : vcount;
				case (in_word.mode)
					kcc_pkg::MODE_CLEAR: begin
						for (int r = 0; r < 64; r++)
							graph_rows[r] <= '0;
					end
					kcc_pkg::MODE_EDGE: begin
						if (in_word.first_vertex < nv && in_word.second_vertex < nv) begin
							graph_rows[in_word.first_vertex][in_word.second_vertex] <= 1'b1;
							if (in_word.first_vertex != in_word.second_vertex)
								graph_rows[in_word.second_vertex][in_word.first_vertex]
									<= 1'b1;
						end
					end
					kcc_pkg::MODE_COUNT: begin
						want.clique_count = count_cliques();
						want.saturated = (want.clique_count == 32'hFFFF_FFFF);
						count_q.push_back(want);
					end
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				checked <= checked + 1;
				if (count_q.size() == 0) begin
					if (errors < 10)
						$display("%0t: result word with no count pending: %0d/%0b", $realtime,
							out_word.clique_count, out_word.saturated);
					errors <= errors + 1;
				end else begin
					want = count_q.pop_front();
					if (want.clique_count !== out_word.clique_count ||
							want.saturated !== out_word.saturated) begin
						if (errors < 10)
							$display("%0t: count mismatch: expected %0d/%0b got %0d/%0b",
								$realtime, want.clique_count, want.saturated,
								out_word.clique_count, out_word.saturated);
						errors <= errors + 1;
					end
				end
			end
			pending <= count_q.size();
		end
	end
endmodule

// ===== tb/sv/k_clique_counter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// k_clique_counter_tb
// Drives clear, edge and count words into the clique counter under several
// register settings, with planted cliques, noise words, random input gaps and
// random output stalls; a checker beside the block predicts and compares every count.
// ----------------------------------------------------------------------------
module k_clique_counter_tb;

	localparam int         IDLE_LIMIT  = 200000;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	kcc_pkg::in_word_t          in_word = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	kcc_pkg::out_word_t         out_word;
	logic                       cfg_we = 1'b0;
	logic [kcc_pkg::CFG_IW-1:0] cfg_index = '0;
	logic [kcc_pkg::CFG_DW-1:0] cfg_data = '0;
	int                         errors, pending, checked;
	int                         idle_cycles = 0;
	int                         words_sent = 0;
	int                         counts_sent = 0;
	int                         settings_used = 0;
	int                         hold_req = 0;
	bit                         quiet = 0;

	always #10 clk = ~clk;

	k_clique_counter dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	k_clique_counter_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending), .checked(checked)
	);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	// receiver: random stall bursts, long holds on request
	initial begin
		int  left, hold_left, hold_seen;
		bit  st;
		left = 0;
		hold_left = 0;
		hold_seen = 0;
		st = 0;
		forever begin
			@(negedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (quiet) begin
				out_stall <= 1'b0;
			end else begin
				if (left == 0) begin
					st = ($urandom_range(0, 2) == 0);
					left = $urandom_range(1, 13);
				end
				left--;
				out_stall <= st;
			end
		end
	end

	task automatic send(logic [1:0] m, int a, int b);
		kcc_pkg::in_word_t w;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		w.mode = m;
		w.first_vertex = 6'(a);
		w.second_vertex = 6'(b);
		in_word <= w;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
		words_sent++;
		if (m == kcc_pkg::MODE_COUNT)
			counts_sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic setup(int vc, int k, int off, int stride);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= kcc_pkg::CFG_VERTEX_COUNT;
		cfg_data <= kcc_pkg::CFG_DW'(vc);
		@(negedge clk);
		cfg_index <= kcc_pkg::CFG_CLIQUE_SIZE;
		cfg_data <= kcc_pkg::CFG_DW'(k);
		@(negedge clk);
		cfg_index <= kcc_pkg::CFG_START_OFFSET;
		cfg_data <= kcc_pkg::CFG_DW'(off);
		@(negedge clk);
		cfg_index <= kcc_pkg::CFG_START_STRIDE;
		cfg_data <= kcc_pkg::CFG_DW'(stride);
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic plant_clique(int nv, int m);
		int vs [$];
		int v;
		while (vs.size() < m) begin
			v = $urandom_range(0, nv - 1);
			if (!(v inside {vs}))
				vs.push_back(v);
		end
		for (int i = 0; i < m; i++)
			for (int j = i + 1; j < m; j++)
				send(kcc_pkg::MODE_EDGE, vs[i], vs[j]);
	endtask

	initial begin
		int vc, k, off, stride, nv, sel;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset settings, empty graph, triangle, noise
		send(kcc_pkg::MODE_COUNT, 0, 0);
		send(kcc_pkg::MODE_EDGE, 0, 63);
		send(kcc_pkg::MODE_EDGE, 0, 1);
		send(kcc_pkg::MODE_EDGE, 1, 2);
		send(kcc_pkg::MODE_EDGE, 2, 0);
		send(kcc_pkg::MODE_EDGE, 5, 5);
		send(MODE_UNUSED, 63, 63);
		send(kcc_pkg::MODE_COUNT, 63, 0);
		// long receiver hold while counts keep coming
		hold_req++;
		repeat (6) send(kcc_pkg::MODE_COUNT, 0, 0);
		setup(127, 2, 0, 1);
		send(kcc_pkg::MODE_COUNT, 0, 0);
		setup(64, 1, 63, 64);
		send(kcc_pkg::MODE_COUNT, 0, 0);
		setup(64, 16, 0, 0);
		send(kcc_pkg::MODE_COUNT, 0, 0);
		setup(3, 17, 0, 1);
		send(kcc_pkg::MODE_COUNT, 0, 0);
		setup(0, 31, 63, 127);
		send(kcc_pkg::MODE_EDGE, 0, 0);
		send(kcc_pkg::MODE_COUNT, 0, 0);
		setup(2, 2, 1, 1);
		send(kcc_pkg::MODE_COUNT, 0, 0);
		send(kcc_pkg::MODE_CLEAR, 0, 0);
		send(kcc_pkg::MODE_COUNT, 0, 0);

		// random phases
		while (words_sent < 500) begin
			sel = $urandom_range(0, 3);
			vc = (sel == 0) ? 64 : (sel == 1) ? $urandom_range(0, 127) : $urandom_range(1, 12);
			nv = (vc > 64) ? 64 : vc;
			k = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 7);
			off = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 2);
			stride = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : 1;
			setup(vc, k, off, stride);
			if (words_sent > 440)
				quiet = 1;
			if (settings_used == 12)
				hold_req++;
			if ($urandom_range(0, 3) != 0)
				send(kcc_pkg::MODE_CLEAR, $urandom, $urandom);
			if (nv >= 2) begin
				if (nv <= 12) begin
					repeat ($urandom_range(1, 3))
						plant_clique(nv, $urandom_range(2, nv));
				end else begin
					plant_clique(nv, $urandom_range(2, 7));
					repeat ($urandom_range(10, 30))
						send(kcc_pkg::MODE_EDGE, $urandom_range(0, nv - 1),
							$urandom_range(0, nv - 1));
				end
			end
			repeat ($urandom_range(2, 4)) begin
				send(kcc_pkg::MODE_COUNT, $urandom, $urandom);
				if ($urandom_range(0, 3) == 0)
					send(kcc_pkg::MODE_EDGE, $urandom, $urandom);
				if ($urandom_range(0, 7) == 0)
					send(MODE_UNUSED, $urandom, $urandom);
			end
		end

		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (50) @(negedge clk);
		$display("words sent %0d, count words %0d, results checked %0d, register settings %0d",
			words_sent, counts_sent, checked, settings_used);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
